### rtl/fpsm_pkg.sv
package fpsm_pkg;

    // Default sizing
    localparam int unsigned MEM_WORDS_DEF = 4096;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned RET_DEPTH_DEF = 16;
    localparam logic [31:0] SENTINEL_DEF  = 32'hFFFF_FFFF;

    // Fixed field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CMD_W    = 5;
    localparam int unsigned PC_W     = 12;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned RET_SKIP = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH, OP_POP, OP_LOAD, OP_STORE, OP_PEEK, OP_POKE, OP_CALL, OP_RET,
        OP_JUMP, OP_JZ, OP_JNZ, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG,
        OP_EQ, OP_NEQ, OP_GT, OP_LT, OP_GEQ, OP_LEQ, OP_LAND, OP_LOR,
        OP_LNOT, OP_BAND, OP_BOR, OP_BNOT, OP_SHL, OP_SHR, OP_WAIT, OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_WB
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] operand;
        logic [PC_W-1:0]   current_address;
    } t_in;

    typedef struct packed {
        logic              jump_taken;
        logic [PC_W-1:0]   jump_target;
        logic              sleep_load;
        logic [TICK_W-1:0] sleep_ticks;
        logic              guard_blocked;
        logic              return_overflow;
    } t_out;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } t_div_res;

    // Two-operand ALU ops
    function automatic logic f_is_binary(input logic [CMD_W-1:0] c);
        logic r;
        unique case (t_op'(c))
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_GT, OP_LT,
            OP_GEQ, OP_LEQ, OP_LAND, OP_LOR, OP_BAND, OP_BOR, OP_SHL,
            OP_SHR: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Stack words an op consumes before it may run
    function automatic logic [1:0] f_min_depth(input logic [CMD_W-1:0] c);
        logic [1:0] r;
        unique case (t_op'(c))
            OP_POP, OP_STORE, OP_PEEK, OP_JZ, OP_JNZ, OP_NEG, OP_LNOT,
            OP_BNOT, OP_WAIT: r = 2'd1;
            OP_POKE: r = 2'd2;
            default: r = f_is_binary(c) ? 2'd2 : 2'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/fpsm_ram.sv
module fpsm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fpsm_div.sv
module fpsm_div #(
    parameter int unsigned FRAC_BITS = fpsm_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output fpsm_pkg::t_div_res  o_res
);

    localparam int unsigned NW = 32 + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [31:0] mag_a, mag_b, q_lo;
    logic [32:0] rem_sh, rem_diff;
    logic        ge;

    assign mag_a = i_a[31] ? (32'd0 - i_a) : i_a;
    assign mag_b = i_b[31] ? (32'd0 - i_b) : i_b;

    // One restoring step per cycle on magnitudes
    always_comb begin
        rem_sh   = {r_rem[31:0], r_num[NW-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = rem_sh >= {1'b0, r_den};
        n_rem    = ge ? rem_diff : rem_sh;
        n_num    = {r_num[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift the quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NW'(mag_a) << FRAC_BITS;
            r_rem <= '0;
            r_den <= mag_b;
            r_neg <= i_a[31] ^ i_b[31];
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign q_lo       = r_num[31:0];
    assign o_res.done = r_done;
    assign o_res.quot = r_neg ? (32'd0 - q_lo) : q_lo;

endmodule

### rtl/fpsm_alu.sv
module fpsm_alu #(
    parameter int unsigned FRAC_BITS = fpsm_pkg::FRAC_BITS_DEF,
    parameter logic [31:0] SENTINEL_VALUE = fpsm_pkg::SENTINEL_DEF
) (
    input  logic        i_clk,
    input  logic [4:0]  i_cmd,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_quot,
    output logic [31:0] o_res
);

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic signed [63:0] r_prod, n_prod;
    logic [31:0] amt;
    logic        long_sh;

    // Register the product before scaling
    assign n_prod = $signed(i_a) * $signed(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign amt     = i_b >> FRAC_BITS;
    assign long_sh = |amt[31:5];

    // Top of stack is b; the word below it is a
    always_comb begin
        unique case (fpsm_pkg::t_op'(i_cmd))
            fpsm_pkg::OP_ADD:  o_res = i_a + i_b;
            fpsm_pkg::OP_SUB:  o_res = i_a - i_b;
            fpsm_pkg::OP_MUL:  o_res = r_prod[FRAC_BITS +: 32];
            fpsm_pkg::OP_DIV:  o_res = (i_b == 32'd0) ? SENTINEL_VALUE : i_quot;
            fpsm_pkg::OP_NEG:  o_res = 32'd0 - i_b;
            fpsm_pkg::OP_EQ:   o_res = (i_a == i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_NEQ:  o_res = (i_a != i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_GT:   o_res = (i_a >  i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_LT:   o_res = (i_a <  i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_GEQ:  o_res = (i_a >= i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_LEQ:  o_res = (i_a <= i_b) ? ONE : 32'd0;
            fpsm_pkg::OP_LAND: o_res = ((i_a != 0) && (i_b != 0)) ? ONE : 32'd0;
            fpsm_pkg::OP_LOR:  o_res = ((i_a != 0) || (i_b != 0)) ? ONE : 32'd0;
            fpsm_pkg::OP_LNOT: o_res = (i_b == 32'd0) ? ONE : 32'd0;
            fpsm_pkg::OP_BAND: o_res = i_a & i_b;
            fpsm_pkg::OP_BOR:  o_res = i_a | i_b;
            fpsm_pkg::OP_BNOT: o_res = ~i_b;
            fpsm_pkg::OP_SHL:  o_res = long_sh ? 32'd0 : (i_a << amt[4:0]);
            fpsm_pkg::OP_SHR:  o_res = long_sh ? 32'd0 : (i_a >> amt[4:0]);
            default:           o_res = 32'd0;
        endcase
    end

endmodule

### rtl/fixed_point_stack_machine_execute_core.sv
// Stack machine execution core: one instruction per input beat, one result beat per
// instruction. The data stack grows down from the top of a single-port-read word memory,
// so the states an instruction passes through follow the memory reads it needs: push,
// jump, call and nop go straight from idle to write-back, as does an instruction the stack
// guard blocks and a return with an empty return stack; pop, load, store, return, jz/jnz,
// wait and the one-operand ops also pass through RD0 and RD1; peek and poke add RD2;
// two-operand ops add RD2 and EXEC, and divide by a non-zero word also waits in its
// bit-serial divider. A stalled result beat holds the core in write-back. After reset the
// core zeroes the word memory, one word per cycle, before taking the first instruction.
module fixed_point_stack_machine_execute_core #(
    parameter int unsigned MEM_WORDS      = fpsm_pkg::MEM_WORDS_DEF,
    parameter int unsigned FRAC_BITS      = fpsm_pkg::FRAC_BITS_DEF,
    parameter int unsigned RET_DEPTH      = fpsm_pkg::RET_DEPTH_DEF,
    parameter logic [31:0] SENTINEL_VALUE = fpsm_pkg::SENTINEL_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fpsm_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fpsm_pkg::t_out o_out
);

    localparam int unsigned AW  = $clog2(MEM_WORDS);
    localparam int unsigned SPW = $clog2(MEM_WORDS + 1);
    localparam int unsigned RAW = (RET_DEPTH > 1) ? $clog2(RET_DEPTH) : 1;
    localparam int unsigned RCW = $clog2(RET_DEPTH + 1);
    localparam logic [32:0] MEM_LIM = 33'(MEM_WORDS);

    fpsm_pkg::t_state r_state, n_state;

    logic [4:0]     r_cmd;
    logic [31:0]    r_opnd;
    logic [11:0]    r_here;
    logic           r_blk;
    logic           r_inr;
    logic [31:0]    r_x, r_y;
    logic [11:0]    r_ret;
    logic [SPW-1:0] r_sp, n_sp;
    logic [RCW-1:0] r_rc, n_rc;
    logic [AW-1:0]  r_clr;
    logic           r_out_valid;
    fpsm_pkg::t_out r_out, n_out;

    logic           accept, guard_ok, wb_fire, out_free;
    logic [1:0]     min_depth;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [RCW-1:0] rc_dec;
    logic [31:0]    x_int, y_int, rd_int, alu_res;
    logic           poke_inr, rd_inr;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [31:0]     mem_wdata, mem_rdata;
    logic            ret_we;
    logic [11:0]     ret_rdata;
    logic            div_start;
    fpsm_pkg::t_div_res div_res;

    assign sp_inc   = r_sp + SPW'(1);
    assign sp_dec   = r_sp - SPW'(1);
    assign rc_dec   = r_rc - RCW'(1);
    assign x_int    = r_x >> FRAC_BITS;
    assign y_int    = r_y >> FRAC_BITS;
    assign rd_int   = mem_rdata >> FRAC_BITS;
    assign poke_inr = {1'b0, y_int} < MEM_LIM;
    assign rd_inr   = {1'b0, rd_int} < MEM_LIM;
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == fpsm_pkg::ST_IDLE) && i_in_valid;
    assign wb_fire  = (r_state == fpsm_pkg::ST_WB) && out_free;

    // Stack depth guard for the incoming beat
    assign min_depth = fpsm_pkg::f_min_depth(i_in.cmd);
    always_comb begin
        priority if (i_in.cmd == fpsm_pkg::OP_PUSH || i_in.cmd == fpsm_pkg::OP_LOAD) begin
            guard_ok = r_sp != '0;
        end else if (min_depth == 2'd1) begin
            guard_ok = r_sp < SPW'(MEM_WORDS);
        end else if (min_depth == 2'd2) begin
            guard_ok = ({1'b0, r_sp} + (SPW+1)'(2)) <= (SPW+1)'(MEM_WORDS);
        end else begin
            guard_ok = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpsm_pkg::ST_CLEAR: begin
                if (r_clr == AW'(MEM_WORDS - 1)) n_state = fpsm_pkg::ST_IDLE;
            end
            fpsm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (guard_ok && (min_depth != 2'd0 || i_in.cmd == fpsm_pkg::OP_LOAD ||
                        (i_in.cmd == fpsm_pkg::OP_RET && r_rc != '0))) begin
                        n_state = fpsm_pkg::ST_RD0;
                    end else begin
                        n_state = fpsm_pkg::ST_WB;
                    end
                end
            end
            fpsm_pkg::ST_RD0: n_state = fpsm_pkg::ST_RD1;
            fpsm_pkg::ST_RD1: begin
                if (r_cmd == fpsm_pkg::OP_PEEK || r_cmd == fpsm_pkg::OP_POKE ||
                    fpsm_pkg::f_is_binary(r_cmd)) begin
                    n_state = fpsm_pkg::ST_RD2;
                end else begin
                    n_state = fpsm_pkg::ST_WB;
                end
            end
            fpsm_pkg::ST_RD2: begin
                n_state = fpsm_pkg::f_is_binary(r_cmd) ? fpsm_pkg::ST_EXEC : fpsm_pkg::ST_WB;
            end
            fpsm_pkg::ST_EXEC: begin
                n_state = div_start ? fpsm_pkg::ST_DIV : fpsm_pkg::ST_WB;
            end
            fpsm_pkg::ST_DIV: begin
                if (div_res.done) n_state = fpsm_pkg::ST_WB;
            end
            fpsm_pkg::ST_WB: begin
                if (out_free) n_state = fpsm_pkg::ST_IDLE;
            end
            default: n_state = fpsm_pkg::ST_IDLE;
        endcase
    end

    // Read addresses and divider start
    always_comb begin
        o_in_stall = r_state != fpsm_pkg::ST_IDLE;
        div_start  = (r_state == fpsm_pkg::ST_EXEC) && (r_cmd == fpsm_pkg::OP_DIV) &&
                     (r_x != 32'd0);
        mem_raddr  = r_sp[AW-1:0];
        if (r_state == fpsm_pkg::ST_RD0 && r_cmd == fpsm_pkg::OP_LOAD) begin
            mem_raddr = r_opnd[AW-1:0];
        end else if (r_state == fpsm_pkg::ST_RD1) begin
            mem_raddr = (r_cmd == fpsm_pkg::OP_PEEK) ? rd_int[AW-1:0] : sp_inc[AW-1:0];
        end
    end

    // Write-back: memory, pointers and the result beat
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sp_dec[AW-1:0];
        mem_wdata = alu_res;
        ret_we    = 1'b0;
        n_sp      = r_sp;
        n_rc      = r_rc;
        n_out     = '0;
        if (r_state == fpsm_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = 32'd0;
        end else if (wb_fire && r_blk) begin
            n_out.guard_blocked = 1'b1;
        end else if (wb_fire) begin
            unique case (fpsm_pkg::t_op'(r_cmd))
                fpsm_pkg::OP_PUSH: begin
                    mem_we    = 1'b1;
                    mem_wdata = r_opnd;
                    n_sp      = sp_dec;
                end
                fpsm_pkg::OP_POP: n_sp = sp_inc;
                fpsm_pkg::OP_LOAD: begin
                    mem_we    = 1'b1;
                    mem_wdata = r_inr ? r_x : 32'd0;
                    n_sp      = sp_dec;
                end
                fpsm_pkg::OP_STORE: begin
                    mem_we    = r_inr;
                    mem_waddr = r_opnd[AW-1:0];
                    mem_wdata = r_x;
                    n_sp      = sp_inc;
                end
                fpsm_pkg::OP_PEEK: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_sp[AW-1:0];
                    mem_wdata = r_inr ? r_y : 32'd0;
                end
                fpsm_pkg::OP_POKE: begin
                    mem_we    = poke_inr;
                    mem_waddr = y_int[AW-1:0];
                    mem_wdata = r_x;
                    n_sp      = r_sp + SPW'(2);
                end
                fpsm_pkg::OP_CALL: begin
                    if (r_rc < RCW'(RET_DEPTH)) begin
                        ret_we = 1'b1;
                        n_rc   = r_rc + RCW'(1);
                    end else begin
                        n_out.return_overflow = 1'b1;
                    end
                    n_out.jump_taken  = 1'b1;
                    n_out.jump_target = r_opnd[11:0];
                end
                fpsm_pkg::OP_RET: begin
                    if (r_rc != '0) begin
                        n_rc              = rc_dec;
                        n_out.jump_taken  = 1'b1;
                        n_out.jump_target = r_ret + 12'(fpsm_pkg::RET_SKIP);
                    end
                end
                fpsm_pkg::OP_JUMP: begin
                    n_out.jump_taken  = 1'b1;
                    n_out.jump_target = r_opnd[11:0];
                end
                fpsm_pkg::OP_JZ, fpsm_pkg::OP_JNZ: begin
                    n_sp = sp_inc;
                    if ((r_cmd == fpsm_pkg::OP_JZ) == (r_x == 32'd0)) begin
                        n_out.jump_taken  = 1'b1;
                        n_out.jump_target = r_opnd[11:0];
                    end
                end
                fpsm_pkg::OP_NEG, fpsm_pkg::OP_LNOT, fpsm_pkg::OP_BNOT: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_sp[AW-1:0];
                end
                fpsm_pkg::OP_WAIT: begin
                    n_sp              = sp_inc;
                    n_out.sleep_load  = 1'b1;
                    n_out.sleep_ticks = x_int[15:0];
                end
                fpsm_pkg::OP_NOP: ;
                default: begin
                    mem_we    = 1'b1;
                    mem_waddr = sp_inc[AW-1:0];
                    n_sp      = sp_inc;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpsm_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_sp        <= SPW'(MEM_WORDS);
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fpsm_pkg::ST_CLEAR) r_clr <= r_clr + AW'(1);
            r_sp <= n_sp;
            r_rc <= n_rc;
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the beat and the words read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_in.cmd;
            r_opnd <= i_in.operand;
            r_here <= i_in.current_address;
            r_blk  <= !guard_ok;
            r_inr  <= {1'b0, i_in.operand} < MEM_LIM;
        end
        if (r_state == fpsm_pkg::ST_RD1) begin
            r_x   <= mem_rdata;
            r_ret <= ret_rdata;
            if (r_cmd == fpsm_pkg::OP_PEEK) r_inr <= rd_inr;
        end
        if (r_state == fpsm_pkg::ST_RD2) r_y <= mem_rdata;
        if (wb_fire) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    fpsm_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_word_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    fpsm_ram #(
        .WIDTH(12),
        .DEPTH(RET_DEPTH)
    ) u_ret_mem (
        .i_clk  (i_clk),
        .i_we   (ret_we),
        .i_waddr(r_rc[RAW-1:0]),
        .i_wdata(r_here),
        .i_raddr(rc_dec[RAW-1:0]),
        .o_rdata(ret_rdata)
    );

    fpsm_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_a    (r_y),
        .i_b    (r_x),
        .o_res  (div_res)
    );

    fpsm_alu #(
        .FRAC_BITS     (FRAC_BITS),
        .SENTINEL_VALUE(SENTINEL_VALUE)
    ) u_alu (
        .i_clk (i_clk),
        .i_cmd (r_cmd),
        .i_a   (r_y),
        .i_b   (r_x),
        .i_quot(div_res.quot),
        .o_res (alu_res)
    );

endmodule

### test/fixed_point_stack_machine_execute_core_tb.sv
`timescale 1ns / 1ps

module fixed_point_stack_machine_execute_core_tb;

    localparam int unsigned MEM_WORDS = fpsm_pkg::MEM_WORDS_DEF;
    localparam int unsigned FRAC_BITS = fpsm_pkg::FRAC_BITS_DEF;
    localparam int unsigned RET_DEPTH = fpsm_pkg::RET_DEPTH_DEF;
    localparam int unsigned WORD_W    = fpsm_pkg::WORD_W;
    localparam int unsigned PC_W      = fpsm_pkg::PC_W;
    localparam int unsigned TICK_W    = fpsm_pkg::TICK_W;
    localparam int unsigned SP_W      = $clog2(MEM_WORDS + 1);

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    fpsm_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    fpsm_pkg::t_out o_out;

    fixed_point_stack_machine_execute_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Shadow machine state
    logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
    logic [SP_W-1:0]   shadow_sp;
    logic [PC_W-1:0]   shadow_ret [RET_DEPTH];
    int unsigned       shadow_ret_cnt;

    fpsm_pkg::t_in  instr_queue [$];
    fpsm_pkg::t_out result_queue [$];
    int   errors;
    bit   stim_done;
    int   send_idle_pct;
    int   recv_idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Append to the tail of each queue
    function automatic void enqueue_instr(input fpsm_pkg::t_in it);
        instr_queue.insert(instr_queue.size(), it);
    endfunction

    function automatic void enqueue_result(input fpsm_pkg::t_out r);
        result_queue.insert(result_queue.size(), r);
    endfunction

    function automatic int unsigned stack_depth();
        return MEM_WORDS - shadow_sp;
    endfunction

    function automatic logic [WORD_W-1:0] mem_rd(input logic [WORD_W-1:0] a);
        return (a < MEM_WORDS) ? shadow_mem[a] : '0;
    endfunction

    function automatic void mem_wr(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] v);
        if (a < MEM_WORDS) shadow_mem[a] = v;
    endfunction

    function automatic void push_w(input logic [WORD_W-1:0] v);
        shadow_sp--;
        shadow_mem[shadow_sp] = v;
    endfunction

    function automatic logic [WORD_W-1:0] pop_w();
        logic [WORD_W-1:0] v;
        v = shadow_mem[shadow_sp];
        shadow_sp++;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] truth(input bit b);
        return b ? (WORD_W'(1) << FRAC_BITS) : '0;
    endfunction

    // Fixed-point multiply and divide on signed words
    function automatic logic [WORD_W-1:0] fx_product(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        p = p >>> FRAC_BITS;
        return p[31:0];
    endfunction

    function automatic logic [WORD_W-1:0] fx_quotient(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] n;
        logic signed [63:0] d;
        logic signed [63:0] q;
        n = $signed({{32{a[31]}}, a}) <<< FRAC_BITS;
        d = $signed({{32{b[31]}}, b});
        q = n / d;
        return q[31:0];
    endfunction

    function automatic fpsm_pkg::t_out execute_instr(input fpsm_pkg::t_in it);
        fpsm_pkg::t_out r;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] sh;
        fpsm_pkg::t_op op;
        r  = '0;
        op = fpsm_pkg::t_op'(it.cmd);
        case (op)
            fpsm_pkg::OP_PUSH, fpsm_pkg::OP_LOAD: begin
                if (shadow_sp > 0)
                    push_w(op == fpsm_pkg::OP_PUSH ? it.operand : mem_rd(it.operand));
                else r.guard_blocked = 1'b1;
            end
            fpsm_pkg::OP_CALL: begin
                if (shadow_ret_cnt < RET_DEPTH) begin
                    shadow_ret[shadow_ret_cnt] = it.current_address;
                    shadow_ret_cnt++;
                end else begin
                    r.return_overflow = 1'b1;
                end
                r.jump_taken  = 1'b1;
                r.jump_target = it.operand[PC_W-1:0];
            end
            fpsm_pkg::OP_RET: begin
                if (shadow_ret_cnt > 0) begin
                    shadow_ret_cnt--;
                    r.jump_taken  = 1'b1;
                    r.jump_target = shadow_ret[shadow_ret_cnt] + PC_W'(fpsm_pkg::RET_SKIP);
                end
            end
            fpsm_pkg::OP_JUMP: begin
                r.jump_taken  = 1'b1;
                r.jump_target = it.operand[PC_W-1:0];
            end
            fpsm_pkg::OP_NOP: ;
            default: begin
                if (stack_depth() < fpsm_pkg::f_min_depth(it.cmd)) begin
                    r.guard_blocked = 1'b1;
                end else begin
                    case (op)
                        fpsm_pkg::OP_POP: void'(pop_w());
                        fpsm_pkg::OP_STORE: mem_wr(it.operand, pop_w());
                        fpsm_pkg::OP_PEEK: push_w(mem_rd(pop_w() >> FRAC_BITS));
                        fpsm_pkg::OP_POKE: begin
                            a = pop_w();
                            b = pop_w();
                            mem_wr(b >> FRAC_BITS, a);
                        end
                        fpsm_pkg::OP_JZ, fpsm_pkg::OP_JNZ: begin
                            a = pop_w();
                            if ((op == fpsm_pkg::OP_JZ) == (a == 0)) begin
                                r.jump_taken  = 1'b1;
                                r.jump_target = it.operand[PC_W-1:0];
                            end
                        end
                        fpsm_pkg::OP_NEG: push_w(-pop_w());
                        fpsm_pkg::OP_LNOT: push_w(truth(pop_w() == 0));
                        fpsm_pkg::OP_BNOT: push_w(~pop_w());
                        fpsm_pkg::OP_WAIT: begin
                            v = pop_w() >> FRAC_BITS;
                            r.sleep_load  = 1'b1;
                            r.sleep_ticks = v[TICK_W-1:0];
                        end
                        default: begin
                            b  = pop_w();
                            a  = pop_w();
                            sh = b >> FRAC_BITS;
                            case (op)
                                fpsm_pkg::OP_ADD:  v = a + b;
                                fpsm_pkg::OP_SUB:  v = a - b;
                                fpsm_pkg::OP_MUL:  v = fx_product(a, b);
                                fpsm_pkg::OP_DIV:
                                    v = (b == 0) ? fpsm_pkg::SENTINEL_DEF : fx_quotient(a, b);
                                fpsm_pkg::OP_EQ:   v = truth(a == b);
                                fpsm_pkg::OP_NEQ:  v = truth(a != b);
                                fpsm_pkg::OP_GT:   v = truth(a > b);
                                fpsm_pkg::OP_LT:   v = truth(a < b);
                                fpsm_pkg::OP_GEQ:  v = truth(a >= b);
                                fpsm_pkg::OP_LEQ:  v = truth(a <= b);
                                fpsm_pkg::OP_LAND: v = truth(a != 0 && b != 0);
                                fpsm_pkg::OP_LOR:  v = truth(a != 0 || b != 0);
                                fpsm_pkg::OP_BAND: v = a & b;
                                fpsm_pkg::OP_BOR:  v = a | b;
                                fpsm_pkg::OP_SHL:  v = (sh >= 32) ? '0 : a << sh;
                                default:           v = (sh >= 32) ? '0 : a >> sh;
                            endcase
                            push_w(v);
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    // Driver: present queued instructions, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) enqueue_result(execute_instr(i_in));
            if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in       <= instr_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: compare result beats against expectations
    always @(posedge i_clk) begin
        fpsm_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected beat", 32'd0, 32'd0);
            end else begin
                want = result_queue.pop_front();
                if (o_out.jump_taken !== want.jump_taken)
                    report_mismatch("jump_taken", 32'(o_out.jump_taken),
                                    32'(want.jump_taken));
                if (o_out.jump_target !== want.jump_target)
                    report_mismatch("jump_target", 32'(o_out.jump_target),
                                    32'(want.jump_target));
                if (o_out.sleep_load !== want.sleep_load)
                    report_mismatch("sleep_load", 32'(o_out.sleep_load),
                                    32'(want.sleep_load));
                if (o_out.sleep_ticks !== want.sleep_ticks)
                    report_mismatch("sleep_ticks", 32'(o_out.sleep_ticks),
                                    32'(want.sleep_ticks));
                if (o_out.guard_blocked !== want.guard_blocked)
                    report_mismatch("guard_blocked", 32'(o_out.guard_blocked),
                                    32'(want.guard_blocked));
                if (o_out.return_overflow !== want.return_overflow)
                    report_mismatch("return_overflow", 32'(o_out.return_overflow),
                                    32'(want.return_overflow));
            end
        end
    end

    function automatic fpsm_pkg::t_in make_instr(input fpsm_pkg::t_op op,
                                                 input logic [31:0] val);
        fpsm_pkg::t_in it;
        it.cmd             = op;
        it.operand         = val;
        it.current_address = PC_W'($urandom);
        return it;
    endfunction

    // Operand biased towards small fixed-point numbers, addresses and edge words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(40) << FRAC_BITS;
            2: return MEM_WORDS - 1 - $urandom_range(20);
            3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            4: return $urandom_range(3);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    // One random instruction; return is issued only when a call site is live
    function automatic fpsm_pkg::t_in random_instr(input int unsigned depth,
                                                   input int unsigned calls);
        fpsm_pkg::t_op op;
        op = fpsm_pkg::t_op'($urandom_range(31));
        if (depth < 3 && $urandom_range(2) != 0) op = fpsm_pkg::OP_PUSH;
        if (depth > 40 && $urandom_range(1) != 0) op = fpsm_pkg::OP_POP;
        if (op == fpsm_pkg::OP_RET && calls == 0) op = fpsm_pkg::OP_CALL;
        return make_instr(op, pick_word());
    endfunction

    task automatic queue_phase(input int count);
        int unsigned depth;
        int unsigned calls;
        fpsm_pkg::t_in it;
        depth = 0;
        calls = 0;
        for (int k = 0; k < count; k++) begin
            it = random_instr(depth, calls);
            case (fpsm_pkg::t_op'(it.cmd))
                fpsm_pkg::OP_PUSH, fpsm_pkg::OP_LOAD: depth++;
                fpsm_pkg::OP_CALL: if (calls < RET_DEPTH) calls++;
                fpsm_pkg::OP_RET: calls--;
                default: if (fpsm_pkg::f_min_depth(it.cmd) <= depth) begin
                    depth -= fpsm_pkg::f_min_depth(it.cmd);
                    if (fpsm_pkg::f_is_binary(it.cmd) ||
                        it.cmd inside {fpsm_pkg::OP_PEEK, fpsm_pkg::OP_NEG,
                                       fpsm_pkg::OP_LNOT, fpsm_pkg::OP_BNOT})
                        depth++;
                end
            endcase
            enqueue_instr(it);
        end
    endtask

    task automatic drain();
        while (instr_queue.size() > 0 || i_in_valid || result_queue.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        errors      = 0;
        stim_done   = 1'b0;
        foreach (shadow_mem[k]) shadow_mem[k] = '0;
        foreach (shadow_ret[k]) shadow_ret[k] = '0;
        shadow_sp      = SP_W'(MEM_WORDS);
        shadow_ret_cnt = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 78;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: guards on an empty stack, extremes, division by zero, long shifts
        enqueue_instr(make_instr(fpsm_pkg::OP_POP, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_ADD, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_RET, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_PUSH, 32'hFFFF_FFFF));
        enqueue_instr(make_instr(fpsm_pkg::OP_POKE, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_PUSH, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_DIV, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_STORE, MEM_WORDS));
        enqueue_instr(make_instr(fpsm_pkg::OP_LOAD, 32'hFFFF_FFFF));
        enqueue_instr(make_instr(fpsm_pkg::OP_PUSH, 32 << FRAC_BITS));
        enqueue_instr(make_instr(fpsm_pkg::OP_SHL, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_PUSH, 32'h8000_0000));
        enqueue_instr(make_instr(fpsm_pkg::OP_PUSH, 32'hFFFF_0000));
        enqueue_instr(make_instr(fpsm_pkg::OP_DIV, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_WAIT, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_JZ, 12'hFFF));
        for (int k = 0; k < RET_DEPTH + 1; k++)
            enqueue_instr(make_instr(fpsm_pkg::OP_CALL, PC_W'($urandom)));
        for (int k = 0; k < RET_DEPTH + 1; k++)
            enqueue_instr(make_instr(fpsm_pkg::OP_RET, 0));
        enqueue_instr(make_instr(fpsm_pkg::OP_JUMP, 32'hFFFF_FFFF));
        enqueue_instr(make_instr(fpsm_pkg::OP_NOP, 32'hFFFF_FFFF));

        queue_phase(450);
        drain();
        send_idle_pct = 78;
        recv_idle_pct = 12;
        queue_phase(450);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phase(500);
        drain();
        repeat (100) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) begin
            $display("[fixed_point_stack_machine_execute_core] OK");
        end else begin
            $display("[fixed_point_stack_machine_execute_core] ERROR");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #20ms;
        $display("[fixed_point_stack_machine_execute_core] ERROR");
        $finish;
    end

endmodule
